// ===== design/assert_macros.svh =====
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed: property violated");

// expression must never be true out of reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("assertion failed: forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ===== design/itf_pkg.sv =====
// shared constants and types for the in-circle tag filter
package itf_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int TAG_BITS       = 32;
	localparam int NUM_FIELDS_XY  = 8;

	// result beat: tag_out, inside_res, padded to whole bytes
	localparam int OUT_BITS = TAG_BITS + 1;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_PAD  = OUT_W - OUT_BITS;

	localparam logic [TAG_BITS-1:0] TAG_REJECT = '1;

	// valid and tag travel together down the pipeline
	typedef struct packed {
		logic                valid;
		logic [TAG_BITS-1:0] tag;
	} itf_beat_t;

endpackage

// ===== design/itf_front.sv =====
// stages 1-2: coordinate differences and first-level products
module itf_front import itf_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  itf_beat_t                        in_beat,
	output logic                             in_ready,
	input  logic signed [COORD_BITS-1:0]     qx,
	input  logic signed [COORD_BITS-1:0]     qy,
	input  logic signed [COORD_BITS-1:0]     vx [3],
	input  logic signed [COORD_BITS-1:0]     vy [3],
	output itf_beat_t                        out_beat,
	input  logic                             out_ready,
	output logic signed [2*COORD_BITS+1:0]   sq_x [3],
	output logic signed [2*COORD_BITS+1:0]   sq_y [3],
	output logic signed [2*COORD_BITS+1:0]   cr_p [3],
	output logic signed [2*COORD_BITS+1:0]   cr_n [3]
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * COORD_BITS + 2;

	logic                  v_s1, v_s2;
	logic [TAG_BITS-1:0]   tag_s1, tag_s2;
	logic signed [DW-1:0]  dx_s1 [3];
	logic signed [DW-1:0]  dy_s1 [3];
	logic signed [PW-1:0]  sq_x_s2 [3];
	logic signed [PW-1:0]  sq_y_s2 [3];
	logic signed [PW-1:0]  cr_p_s2 [3];
	logic signed [PW-1:0]  cr_n_s2 [3];
	logic                  rdy_s1, rdy_s2;

	// a stage takes a new beat when empty or when its content moves on
	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_beat.valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_beat.valid) begin
			tag_s1 <= in_beat.tag;
			for (int i = 0; i < 3; i++) begin
				dx_s1[i] <= DW'(vx[i]) - DW'(qx);
				dy_s1[i] <= DW'(vy[i]) - DW'(qy);
			end
		end
	end

	// minor t pairs the two vertices other than t, in cyclic order
	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			tag_s2 <= tag_s1;
			for (int i = 0; i < 3; i++) begin
				sq_x_s2[i] <= PW'(dx_s1[i]) * PW'(dx_s1[i]);
				sq_y_s2[i] <= PW'(dy_s1[i]) * PW'(dy_s1[i]);
			end
			cr_p_s2[0] <= PW'(dx_s1[1]) * PW'(dy_s1[2]);
			cr_n_s2[0] <= PW'(dx_s1[2]) * PW'(dy_s1[1]);
			cr_p_s2[1] <= PW'(dx_s1[2]) * PW'(dy_s1[0]);
			cr_n_s2[1] <= PW'(dx_s1[0]) * PW'(dy_s1[2]);
			cr_p_s2[2] <= PW'(dx_s1[0]) * PW'(dy_s1[1]);
			cr_n_s2[2] <= PW'(dx_s1[1]) * PW'(dy_s1[0]);
		end
	end

	assign out_beat.valid = v_s2;
	assign out_beat.tag   = tag_s2;
	assign sq_x = sq_x_s2;
	assign sq_y = sq_y_s2;
	assign cr_p = cr_p_s2;
	assign cr_n = cr_n_s2;

endmodule

// ===== design/itf_minor.sv =====
// stage 3: squared lengths and signed 2x2 minors
module itf_minor import itf_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  itf_beat_t                        in_beat,
	output logic                             in_ready,
	input  logic signed [2*COORD_BITS+1:0]   sq_x [3],
	input  logic signed [2*COORD_BITS+1:0]   sq_y [3],
	input  logic signed [2*COORD_BITS+1:0]   cr_p [3],
	input  logic signed [2*COORD_BITS+1:0]   cr_n [3],
	output itf_beat_t                        out_beat,
	input  logic                             out_ready,
	output logic signed [2*COORD_BITS+2:0]   sq [3],
	output logic signed [2*COORD_BITS+2:0]   mn [3]
);

	localparam int MW = 2 * COORD_BITS + 3;

	logic                  v_s3;
	logic [TAG_BITS-1:0]   tag_s3;
	logic signed [MW-1:0]  sq_s3 [3];
	logic signed [MW-1:0]  mn_s3 [3];
	logic                  rdy_s3;

	assign rdy_s3   = !v_s3 || out_ready;
	assign in_ready = rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= in_beat.valid;
		end
	end

	// the middle minor comes out negated so the three terms simply add
	always_ff @(posedge clk) begin
		if (rdy_s3 && in_beat.valid) begin
			tag_s3 <= in_beat.tag;
			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= MW'(sq_x[i]) + MW'(sq_y[i]);
				mn_s3[i] <= MW'(cr_p[i]) - MW'(cr_n[i]);
			end
		end
	end

	assign out_beat.valid = v_s3;
	assign out_beat.tag   = tag_s3;
	assign sq = sq_s3;
	assign mn = mn_s3;

endmodule

// ===== design/itf_term.sv =====
// stages 4-5: split multiply of squared length by minor
module itf_term import itf_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  itf_beat_t                        in_beat,
	output logic                             in_ready,
	input  logic signed [2*COORD_BITS+2:0]   sq [3],
	input  logic signed [2*COORD_BITS+2:0]   mn [3],
	output itf_beat_t                        out_beat,
	input  logic                             out_ready,
	output logic signed [4*COORD_BITS+7:0]   term [3]
);

	localparam int MW  = 2 * COORD_BITS + 3;
	localparam int LO  = (MW + 1) / 2;
	localparam int HI  = MW - LO;
	localparam int LLW = 2 * LO;
	localparam int XW  = LO + 1 + HI;
	localparam int HHW = 2 * HI;
	localparam int TW  = 2 * MW + 2;

	logic                 v_s4, v_s5;
	logic [TAG_BITS-1:0]  tag_s4, tag_s5;
	logic                 rdy_s4, rdy_s5;

	logic [LLW-1:0]        ll_s4 [3];
	logic signed [XW-1:0]  lh_s4 [3];
	logic signed [XW-1:0]  hl_s4 [3];
	logic signed [HHW-1:0] hh_s4 [3];
	logic signed [TW-1:0]  term_s5 [3];

	assign rdy_s5   = !v_s5 || out_ready;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign in_ready = rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s4) begin
				v_s4 <= in_beat.valid;
			end
			if (rdy_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && in_beat.valid) begin
			tag_s4 <= in_beat.tag;
		end
		if (rdy_s5 && v_s4) begin
			tag_s5 <= tag_s4;
		end
	end

	for (genvar t = 0; t < 3; t++) begin : g_term
		logic [LO-1:0]        sq_lo, mn_lo;
		logic signed [HI-1:0] sq_hi, mn_hi;

		// low halves unsigned, high halves carry the sign
		assign sq_lo = sq[t][LO-1:0];
		assign mn_lo = mn[t][LO-1:0];
		assign sq_hi = $signed(sq[t][MW-1:LO]);
		assign mn_hi = $signed(mn[t][MW-1:LO]);

		always_ff @(posedge clk) begin
			if (rdy_s4 && in_beat.valid) begin
				ll_s4[t] <= LLW'(sq_lo) * LLW'(mn_lo);
				lh_s4[t] <= XW'($signed({1'b0, sq_lo})) * XW'(mn_hi);
				hl_s4[t] <= XW'(sq_hi) * XW'($signed({1'b0, mn_lo}));
				hh_s4[t] <= HHW'(sq_hi) * HHW'(mn_hi);
			end
		end

		always_ff @(posedge clk) begin
			if (rdy_s5 && v_s4) begin
				term_s5[t] <= (TW'(hh_s4[t]) << (2 * LO))
					+ ((TW'(lh_s4[t]) + TW'(hl_s4[t])) << LO)
					+ TW'(ll_s4[t]);
			end
		end
	end

	assign out_beat.valid = v_s5;
	assign out_beat.tag   = tag_s5;
	assign term = term_s5;

endmodule

// ===== design/itf_sum.sv =====
// stages 6-7: determinant sum, sign test and tag decision
module itf_sum import itf_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  itf_beat_t                        in_beat,
	output logic                             in_ready,
	input  logic signed [4*COORD_BITS+7:0]   term [3],
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [TAG_BITS-1:0]              tag_out,
	output logic                             inside_res
);

	localparam int TW = 4 * COORD_BITS + 8;

	logic                  v_s6, v_s7;
	logic [TAG_BITS-1:0]   tag_s6, tag_s7;
	logic signed [TW-1:0]  det_s6;
	logic                  inside_s7;
	logic                  rdy_s6, rdy_s7;
	logic                  det_pos;

	assign rdy_s7   = !v_s7 || out_ready;
	assign rdy_s6   = !v_s6 || rdy_s7;
	assign in_ready = rdy_s6;

	// zero determinant counts as outside
	assign det_pos = !det_s6[TW-1] && (|det_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy_s6) begin
				v_s6 <= in_beat.valid;
			end
			if (rdy_s7) begin
				v_s7 <= v_s6;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s6 && in_beat.valid) begin
			tag_s6 <= in_beat.tag;
			det_s6 <= term[0] + term[1] + term[2];
		end
		if (rdy_s7 && v_s6) begin
			inside_s7 <= det_pos;
			tag_s7    <= (det_pos && (tag_s6 != TAG_REJECT)) ? tag_s6 : TAG_REJECT;
		end
	end

	assign out_valid  = v_s7;
	assign tag_out    = tag_s7;
	assign inside_res = inside_s7;

endmodule

// ===== design/incircle_tag_filter.sv =====
// top level of the in-circle tag filter
`include "assert_macros.svh"

// Tests whether a query point lies strictly inside the circle through three
// counter-clockwise triangle vertices, in exact integer arithmetic, and passes
// the tag through only when it does and the tag is not already -1; otherwise
// it becomes -1. One beat is accepted per clock unless stalled; it then passes
// two stages of differences and products, one of squared lengths and minors,
// two of split wide multiplication, and two of summing and deciding. Each stage
// holds its own valid bit, so bubbles close up under back-pressure and s_tready
// only drops when all seven stages are full and the output beat is not taken.
module incircle_tag_filter import itf_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// query_x, query_y, vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x,
	// vert_c_y, tag_in
	input  logic [NUM_FIELDS_XY*COORD_BITS+TAG_BITS-1:0] s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// tag_out, inside_res, zero fill
	output logic [OUT_W-1:0]                     m_tdata
);

	localparam int PW = 2 * COORD_BITS + 2;
	localparam int MW = 2 * COORD_BITS + 3;
	localparam int TW = 4 * COORD_BITS + 8;

	itf_beat_t                   in_beat, b_front, b_minor, b_term;
	logic                        r_front, r_minor, r_term;
	logic signed [COORD_BITS-1:0] qx, qy;
	logic signed [COORD_BITS-1:0] vx [3];
	logic signed [COORD_BITS-1:0] vy [3];
	logic signed [PW-1:0]        sq_x [3];
	logic signed [PW-1:0]        sq_y [3];
	logic signed [PW-1:0]        cr_p [3];
	logic signed [PW-1:0]        cr_n [3];
	logic signed [MW-1:0]        sq [3];
	logic signed [MW-1:0]        mn [3];
	logic signed [TW-1:0]        term [3];
	logic [TAG_BITS-1:0]         tag_out;
	logic                        inside_res;

	assign qx = $signed(s_tdata[0 +: COORD_BITS]);
	assign qy = $signed(s_tdata[COORD_BITS +: COORD_BITS]);
	for (genvar k = 0; k < 3; k++) begin : g_vert
		assign vx[k] = $signed(s_tdata[(2 + 2 * k) * COORD_BITS +: COORD_BITS]);
		assign vy[k] = $signed(s_tdata[(3 + 2 * k) * COORD_BITS +: COORD_BITS]);
	end

	assign in_beat.valid = s_tvalid;
	assign in_beat.tag   = s_tdata[NUM_FIELDS_XY * COORD_BITS +: TAG_BITS];

	itf_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_beat   (in_beat),
		.in_ready  (s_tready),
		.qx        (qx),
		.qy        (qy),
		.vx        (vx),
		.vy        (vy),
		.out_beat  (b_front),
		.out_ready (r_front),
		.sq_x      (sq_x),
		.sq_y      (sq_y),
		.cr_p      (cr_p),
		.cr_n      (cr_n)
	);

	itf_minor #(.COORD_BITS(COORD_BITS)) u_minor (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_beat   (b_front),
		.in_ready  (r_front),
		.sq_x      (sq_x),
		.sq_y      (sq_y),
		.cr_p      (cr_p),
		.cr_n      (cr_n),
		.out_beat  (b_minor),
		.out_ready (r_minor),
		.sq        (sq),
		.mn        (mn)
	);

	itf_term #(.COORD_BITS(COORD_BITS)) u_term (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_beat   (b_minor),
		.in_ready  (r_minor),
		.sq        (sq),
		.mn        (mn),
		.out_beat  (b_term),
		.out_ready (r_term),
		.term      (term)
	);

	itf_sum #(.COORD_BITS(COORD_BITS)) u_sum (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_beat    (b_term),
		.in_ready   (r_term),
		.term       (term),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.tag_out    (tag_out),
		.inside_res (inside_res)
	);

	assign m_tdata = {{OUT_PAD{1'b0}}, inside_res, tag_out};

	// a tag only survives when the point tested inside
	`ASSERT_PROP(a_pass_needs_inside, clk, arst_n, m_tvalid && (m_tdata[TAG_BITS-1:0] != TAG_REJECT) |-> m_tdata[TAG_BITS])
	// input back-pressure only comes from a stalled output beat
	`ASSERT_NEVER(a_stall_without_cause, clk, arst_n, !s_tready && !(m_tvalid && !m_tready))

endmodule

// ===== test/tb_top.sv =====
// testbench for the in-circle tag filter: table-driven and random beats against a predictor
module tb_top;
	import itf_pkg::*;

	localparam int CW     = COORD_BITS_DEF;
	localparam int IN_W   = NUM_FIELDS_XY * CW + TAG_BITS;
	localparam int N_RAND = 325;

	localparam logic signed [CW-1:0] CMIN = 16'sh8000;
	localparam logic signed [CW-1:0] CMAX = 16'sh7fff;
	localparam logic signed [CW-1:0] Z    = 16'sd0;
	localparam logic signed [CW-1:0] P1   = 16'sd1;
	localparam logic signed [CW-1:0] N1   = -16'sd1;

	typedef struct packed {
		logic [TAG_BITS-1:0] tag;
		logic                in_circle;
	} verdict_t;

	// known: expected verdict typed in the row, otherwise computed
	typedef struct packed {
		logic signed [CW-1:0] qx, qy, ax, ay, bx, by, cx, cy;
		logic [TAG_BITS-1:0]  tag;
		logic                 known;
		logic [TAG_BITS-1:0]  etag;
		logic                 einside;
	} query_row_t;

	logic            clk      = 1'b0;
	logic            arst_n   = 1'b0;
	logic            s_tvalid = 1'b0;
	logic            s_tready;
	logic [IN_W-1:0] s_tdata  = '0;
	logic            m_tvalid;
	logic            m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	verdict_t verdict_q [$];
	int       mismatch_count = 0;
	int       tx_idle_pct    = 0;
	int       rx_stall_pct   = 0;
	logic     rx_hold        = 1'b0;
	logic     hold_go        = 1'b0;

	int circ_x [12] = '{5, 4, 3, 0, -3, -4, -5, -4, -3, 0, 3, 4};
	int circ_y [12] = '{0, 3, 4, 5, 4, 3, 0, -3, -4, -5, -4, -3};

	query_row_t dir_rows [19] = '{
		// all coordinates zero: zero determinant
		'{Z, Z, Z, Z, Z, Z, Z, Z, 32'h00000000, 1'b1, TAG_REJECT, 1'b0},
		// origin inside the circle of a counter-clockwise unit triangle
		'{Z, Z, P1, Z, Z, P1, N1, Z, 32'h12345678, 1'b1, 32'h12345678, 1'b1},
		// same point, tag already rejected
		'{Z, Z, P1, Z, Z, P1, N1, Z, TAG_REJECT, 1'b1, TAG_REJECT, 1'b1},
		// clockwise order flips the sign
		'{Z, Z, P1, Z, N1, Z, Z, P1, 32'hA5A5A5A5, 1'b1, TAG_REJECT, 1'b0},
		// point exactly on the circle
		'{Z, N1, P1, Z, Z, P1, N1, Z, 32'h0BADF00D, 1'b1, TAG_REJECT, 1'b0},
		'{16'sd100, 16'sd100, P1, Z, Z, P1, N1, Z, 32'h00000001, 1'b0, '0, 1'b0},
		'{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 32'h7FFFFFFF, 1'b1, TAG_REJECT, 1'b0},
		'{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 32'h80000000, 1'b1, TAG_REJECT, 1'b0},
		'{CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, 32'h00000002, 1'b0, '0, 1'b0},
		'{Z, Z, CMAX, Z, Z, CMAX, CMIN, Z, 32'h00000000, 1'b0, '0, 1'b0},
		'{CMAX, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, Z, 32'h55555555, 1'b0, '0, 1'b0},
		'{CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, Z, CMIN, 32'hAAAAAAAA, 1'b0, '0, 1'b0},
		'{P1, P1, Z, Z, 16'sd10, Z, Z, 16'sd10, 32'hFFFFFFFE, 1'b0, '0, 1'b0},
		'{P1, P1, Z, Z, 16'sd10, Z, Z, 16'sd10, 32'h80000000, 1'b0, '0, 1'b0},
		// query sits on a vertex
		'{16'sd7, -16'sd3, 16'sd7, -16'sd3, 16'sd20, 16'sd5, -16'sd4, 16'sd9,
			32'h00000001, 1'b1, TAG_REJECT, 1'b0},
		// collinear vertices
		'{16'sd5, N1, Z, Z, P1, P1, 16'sd2, 16'sd2, 32'h7FFFFFFF, 1'b0, '0, 1'b0},
		'{N1, N1, CMAX, CMIN, CMIN, CMIN, Z, CMAX, 32'hDEADBEEF, 1'b0, '0, 1'b0},
		'{Z, Z, P1, Z, N1, Z, Z, P1, TAG_REJECT, 1'b1, TAG_REJECT, 1'b0},
		'{N1, N1, N1, N1, N1, N1, N1, N1, 32'h0000FFFF, 1'b1, TAG_REJECT, 1'b0}
	};

	incircle_tag_filter i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// exact in-circle determinant on wide signed integers
	function automatic verdict_t incircle_verdict(query_row_t r);
		logic signed [95:0] dxa, dya, dxb, dyb, dxc, dyc;
		logic signed [95:0] sqa, sqb, sqc, m1, m2, m3, det;
		verdict_t v;
		dxa = $signed(r.ax) - $signed(r.qx);
		dya = $signed(r.ay) - $signed(r.qy);
		dxb = $signed(r.bx) - $signed(r.qx);
		dyb = $signed(r.by) - $signed(r.qy);
		dxc = $signed(r.cx) - $signed(r.qx);
		dyc = $signed(r.cy) - $signed(r.qy);
		sqa = dxa * dxa + dya * dya;
		sqb = dxb * dxb + dyb * dyb;
		sqc = dxc * dxc + dyc * dyc;
		m1 = dxb * dyc - dxc * dyb;
		m2 = dxa * dyc - dxc * dya;
		m3 = dxa * dyb - dxb * dya;
		det = sqa * m1 - sqb * m2 + sqc * m3;
		v.in_circle = (det > 0);
		v.tag = (r.tag != TAG_REJECT && v.in_circle) ? r.tag : TAG_REJECT;
		return v;
	endfunction

	task automatic send_query(input query_row_t r);
		verdict_t v;
		if (r.known) begin
			v = '{r.etag, r.einside};
		end else begin
			v = incircle_verdict(r);
		end
		s_tdata  <= {r.tag, r.cy, r.cx, r.by, r.bx, r.ay, r.ax, r.qy, r.qx};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		verdict_q.push_back(v);
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
	endtask

	always @(posedge clk) begin
		m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
	end

	// long receiver hold-off so the pipeline fills and stalls the input
	initial begin
		wait (hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (200) @(posedge clk);
		rx_hold <= 1'b0;
	end

	always @(posedge clk) begin : result_check
		verdict_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (verdict_q.size() == 0) begin
				$display("%0t: result beat with nothing expected: expected none, actual %h",
					$time, m_tdata);
				mismatch_count++;
			end else begin
				want = verdict_q.pop_front();
				if (m_tdata[TAG_BITS-1:0] !== want.tag) begin
					$display("%0t: tag_out mismatch: expected %h, actual %h",
						$time, want.tag, m_tdata[TAG_BITS-1:0]);
					mismatch_count++;
				end
				if (m_tdata[TAG_BITS] !== want.in_circle) begin
					$display("%0t: inside_res mismatch: expected %b, actual %b",
						$time, want.in_circle, m_tdata[TAG_BITS]);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		query_row_t r;
		int c [8];
		int kind, org_x, org_y, spread, k, j, t;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) send_query(dir_rows[i]);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  hold_go = 1'b1; end
				1: begin tx_idle_pct = 75; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 75; end
				default: begin tx_idle_pct = 37; rx_stall_pct = 37; end
			endcase
			for (int n = 0; n < N_RAND; n++) begin
				kind = $urandom_range(9);
				if (kind <= 4 || kind == 8) begin
					// small triangle somewhere in the plane
					org_x  = int'($urandom_range(62000)) - 31000;
					org_y  = int'($urandom_range(62000)) - 31000;
					spread = 1 << $urandom_range(8);
					for (int i = 0; i < 8; i++)
						c[i] = ((i % 2 == 0) ? org_x : org_y)
							+ int'($urandom_range(2 * spread)) - spread;
					if (kind == 8) begin
						// degenerate shapes: query on a vertex, repeated or collinear vertices
						case ($urandom_range(2))
							0: begin c[0] = c[2]; c[1] = c[3]; end
							1: begin c[4] = c[2]; c[5] = c[3]; end
							default: begin c[6] = 2 * c[4] - c[2]; c[7] = 2 * c[5] - c[3]; end
						endcase
					end
				end else if (kind == 6) begin
					for (int i = 0; i < 8; i++)
						case ($urandom_range(4))
							0: c[i] = -32768;
							1: c[i] = 32767;
							2: c[i] = 0;
							3: c[i] = -1;
							default: c[i] = int'($urandom_range(65535)) - 32768;
						endcase
				end else if (kind == 7) begin
					// four points on one circle: determinant is zero
					org_x = int'($urandom_range(60000)) - 30000;
					org_y = int'($urandom_range(60000)) - 30000;
					k = $urandom_range(50, 1);
					for (int i = 0; i < 4; i++) begin
						j = $urandom_range(11);
						c[2 * i]     = org_x + k * circ_x[j];
						c[2 * i + 1] = org_y + k * circ_y[j];
					end
				end else begin
					for (int i = 0; i < 8; i++)
						c[i] = int'($urandom_range(65535)) - 32768;
				end
				r.qx = c[0][CW-1:0];
				r.qy = c[1][CW-1:0];
				r.ax = c[2][CW-1:0];
				r.ay = c[3][CW-1:0];
				r.bx = c[4][CW-1:0];
				r.by = c[5][CW-1:0];
				r.cx = c[6][CW-1:0];
				r.cy = c[7][CW-1:0];
				t = $urandom_range(7);
				if (t == 0) begin
					r.tag = TAG_REJECT;
				end else if (t == 1) begin
					case ($urandom_range(3))
						0: r.tag = 32'h00000000;
						1: r.tag = 32'h7FFFFFFF;
						2: r.tag = 32'h80000000;
						default: r.tag = 32'hFFFFFFFE;
					endcase
				end else begin
					r.tag = $urandom;
				end
				r.known   = 1'b0;
				r.etag    = '0;
				r.einside = 1'b0;
				send_query(r);
			end
		end
		s_tvalid <= 1'b0;
		rx_stall_pct = 0;

		while (verdict_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("tb_top failed");
		$finish;
	end

endmodule

// ===== incircle_tag_filter.f =====
+incdir+design
design/itf_pkg.sv
design/itf_front.sv
design/itf_minor.sv
design/itf_term.sv
design/itf_sum.sv
design/incircle_tag_filter.sv
test/tb_top.sv
